@@ rtl/wps_pkg.sv @@
// Shared types and constants for the wheel pulse speedometer.
`default_nettype none
package wps_pkg;

    localparam int TS_W    = 32;
    localparam int SPEED_W = 16;
    localparam int DIST_W  = 32;
    localparam int CIRC_W  = 12;
    localparam int CPS_W   = 16;
    localparam int PROD_W  = CIRC_W + CPS_W;     // circumference * counts
    localparam int NUM_W   = PROD_W + 6;         // times 36
    localparam int DEN_W   = TS_W + 10;          // interval times 1000
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [CIRC_W-1:0]  CIRC_RST  = 12'd2000;
    localparam logic [CPS_W-1:0]   CPS_RST   = 16'd1000;
    localparam logic [SPEED_W-1:0] LIMIT_RST = 16'd1000;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CIRC  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CPS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_LIMIT = 2'd2;

    // Item kinds
    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_ARMED     = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_TICK_SAME = 3'd3,
        ST_TICK_LOW  = 3'd4,
        ST_DUPLICATE = 3'd5
    } wps_status_t;

    typedef struct packed {
        logic            action;
        logic [TS_W-1:0] timestamp;
    } wps_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_tenths_kmh;
        logic [DIST_W-1:0]  distance_mm;
        wps_status_t        status;
        logic               display_changed;
    } wps_out_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } wps_div_stat_t;

endpackage
`default_nettype wire

@@ rtl/wps_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, saturated result.
`default_nettype none
module wps_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [wps_pkg::NUM_W-1:0]    dividend,
    input  wire logic [wps_pkg::DEN_W-1:0]    divisor,
    output wps_pkg::wps_div_stat_t            stat,
    output logic      [wps_pkg::SPEED_W-1:0]  quotient
);

    logic [wps_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [wps_pkg::DEN_W-1:0] div_reg;
    logic [wps_pkg::NUM_W-1:0] quo_reg;
    logic [wps_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg, done_reg;
    logic [wps_pkg::DEN_W:0]   trial, diff;
    logic                      ge;

    // Shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial    = {rem_reg, quo_reg[wps_pkg::NUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[wps_pkg::DEN_W-1:0] : trial[wps_pkg::DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wps_pkg::CNT_W'(wps_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wps_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[wps_pkg::NUM_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = (|quo_reg[wps_pkg::NUM_W-1:wps_pkg::SPEED_W]) ? '1
                                                                       : quo_reg[wps_pkg::SPEED_W-1:0];

endmodule
`default_nettype wire

@@ rtl/wheel_pulse_speedometer_top.sv @@
// Top level: wheel speed and odometer from pulse timestamps and second ticks.
//
//  channel  | ports                       | direction | content
//  ---------+-----------------------------+-----------+--------------------------
//  input    | s_valid s_ready s_data      | in        | action, timestamp
//  result   | m_valid m_ready m_data      | out       | speed, distance, status
//  config   | cfg_we cfg_index cfg_wdata  | in        | circ, counts/s, limit
//
// An item that needs a speed passes from its input transfer until the block
// is ready again through one multiply, one scale step, a divider start, the
// bit-serial divider (one bit of the 34-bit numerator per cycle) and a wait
// to see it finish, the update, and the return to idle. Duplicates, arming
// pulses and ticks at zero interval go straight to the final state.
// Reset (aresetn low, synchronous) clears the stored time, speed and odometer
// and loads the register defaults. A result waits in the output register
// while m_ready is low; the next item may already be taken and computed, and
// it holds in the final state until the output register is free.
`default_nettype none
module wheel_pulse_speedometer_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire wps_pkg::wps_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output wps_pkg::wps_out_t                 m_data,
    input  wire logic                         cfg_we,
    input  wire logic [wps_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [wps_pkg::CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCALE, S_DIV, S_WAIT, S_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [wps_pkg::CIRC_W-1:0]  circ_reg;
    logic [wps_pkg::CPS_W-1:0]   cps_reg;
    logic [wps_pkg::SPEED_W-1:0] limit_reg;

    // block state
    logic [wps_pkg::TS_W-1:0]    last_reg;
    logic [wps_pkg::SPEED_W-1:0] held_reg;
    logic [wps_pkg::DIST_W-1:0]  odo_reg;

    // working registers for the item in flight
    logic                        act_reg;
    logic [wps_pkg::TS_W-1:0]    ts_reg;
    logic [wps_pkg::TS_W-1:0]    ival_reg;
    logic [wps_pkg::PROD_W-1:0]  prod_reg;
    logic [wps_pkg::NUM_W-1:0]   num_reg;
    logic [wps_pkg::DEN_W-1:0]   den_reg;
    wps_pkg::wps_status_t        status_reg;
    logic                        chg_reg;
    logic                        m_valid_reg;
    wps_pkg::wps_out_t           m_data_reg;

    logic                        in_xfer;
    logic [wps_pkg::TS_W-1:0]    ival_in;
    logic [wps_pkg::DEN_W-1:0]   ival_x;
    logic [wps_pkg::NUM_W-1:0]   prod_x;
    logic [wps_pkg::DIST_W:0]    odo_sum;
    logic                        div_start;
    wps_pkg::wps_div_stat_t      div_stat;
    logic [wps_pkg::SPEED_W-1:0] div_q;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign ival_in   = s_data.timestamp - last_reg;   // wraps mod 2^32
    assign ival_x    = {{(wps_pkg::DEN_W-wps_pkg::TS_W){1'b0}}, ival_reg};
    assign prod_x    = {{(wps_pkg::NUM_W-wps_pkg::PROD_W){1'b0}}, prod_reg};
    assign odo_sum   = {1'b0, odo_reg}
                     + {{(wps_pkg::DIST_W+1-wps_pkg::CIRC_W){1'b0}}, circ_reg};
    assign div_start = (state_reg == S_DIV);

    wps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            circ_reg  <= wps_pkg::CIRC_RST;
            cps_reg   <= wps_pkg::CPS_RST;
            limit_reg <= wps_pkg::LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wps_pkg::REG_CIRC:  circ_reg  <= cfg_wdata[wps_pkg::CIRC_W-1:0];
                wps_pkg::REG_CPS:   cps_reg   <= cfg_wdata[wps_pkg::CPS_W-1:0];
                wps_pkg::REG_LIMIT: limit_reg <= cfg_wdata[wps_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, block state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            last_reg    <= '0;
            held_reg    <= '0;
            odo_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the final state reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        act_reg  <= s_data.action;
                        ts_reg   <= s_data.timestamp;
                        ival_reg <= ival_in;
                        chg_reg  <= 1'b0;
                        state_reg <= S_MUL;
                        if (s_data.action == wps_pkg::ACT_PULSE) begin
                            if (s_data.timestamp == last_reg) begin
                                status_reg <= wps_pkg::ST_DUPLICATE;
                                state_reg  <= S_FIN;
                            end else if (last_reg == '0) begin
                                last_reg   <= s_data.timestamp;
                                status_reg <= wps_pkg::ST_ARMED;
                                state_reg  <= S_FIN;
                            end
                        end else if (ival_in == '0) begin
                            // zero interval counts as infinite speed
                            status_reg <= wps_pkg::ST_TICK_SAME;
                            state_reg  <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= wps_pkg::PROD_W'(circ_reg) * wps_pkg::PROD_W'(cps_reg);
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    // num = prod * 36, den = interval * 1000
                    num_reg   <= (prod_x << 5) + (prod_x << 2);
                    den_reg   <= (ival_x << 10) - (ival_x << 4) - (ival_x << 3);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_stat.done) begin
                        state_reg <= S_FIN;
                        if (act_reg == wps_pkg::ACT_PULSE) begin
                            // saturated quotient never passes a 16-bit limit
                            if (div_q < limit_reg) begin
                                held_reg   <= div_q;
                                odo_reg    <= odo_sum[wps_pkg::DIST_W] ? '1
                                                : odo_sum[wps_pkg::DIST_W-1:0];
                                last_reg   <= ts_reg;
                                status_reg <= wps_pkg::ST_ACCEPTED;
                                chg_reg    <= 1'b1;
                            end else begin
                                status_reg <= wps_pkg::ST_REJECTED;
                            end
                        end else if (div_q < held_reg) begin
                            held_reg   <= div_q;
                            status_reg <= wps_pkg::ST_TICK_LOW;
                            chg_reg    <= 1'b1;
                        end else begin
                            status_reg <= wps_pkg::ST_TICK_SAME;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                 <= 1'b1;
                        m_data_reg.speed_tenths_kmh <= held_reg;
                        m_data_reg.distance_mm      <= odo_reg;
                        m_data_reg.status           <= status_reg;
                        m_data_reg.display_changed  <= chg_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted transfer always takes the block busy.
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input taken while an item is in flight");

    // The divider reports completion only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_WAIT))
        else $error("divider done outside wait state");

    // The divider is idle whenever the block takes input.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while idle");

    // The change flag matches the status codes that update the display.
    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.display_changed ==
                     ((m_data.status == wps_pkg::ST_ACCEPTED) ||
                      (m_data.status == wps_pkg::ST_TICK_LOW))))
        else $error("display_changed disagrees with status");

endmodule
`default_nettype wire

@@ test/tb_wheel_pulse_speedometer_top.sv @@
// Self-checking testbench for the wheel pulse speedometer: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_wheel_pulse_speedometer_top;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------
    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    wps_pkg::wps_in_t            s_data    = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    wps_pkg::wps_out_t           m_data;
    logic                        cfg_we    = 1'b0;
    logic [wps_pkg::IDX_W-1:0]   cfg_index = wps_pkg::REG_CIRC;
    logic [wps_pkg::CFG_W-1:0]   cfg_wdata = '0;

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    wheel_pulse_speedometer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Speedometer model: registers and stored state, at reset values.
    // Updated once per accepted input transfer, in acceptance order.
    // ------------------------------------------------------------------
    logic [wps_pkg::CIRC_W-1:0]  cfg_circ    = wps_pkg::CIRC_RST;
    logic [wps_pkg::CPS_W-1:0]   cfg_cps     = wps_pkg::CPS_RST;
    logic [wps_pkg::SPEED_W-1:0] cfg_limit   = wps_pkg::LIMIT_RST;
    logic [wps_pkg::TS_W-1:0]    pulse_time  = '0;     // zero means not armed
    logic [wps_pkg::SPEED_W-1:0] held_speed  = '0;
    logic [wps_pkg::DIST_W-1:0]  odometer_mm = '0;

    // Readings still owed by the block, oldest first
    wps_pkg::wps_out_t pending_readings[$];

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned settings_used = 1;     // reset defaults count as the first
    int unsigned status_seen [8];

    // Idle percentages; the sender task and the receiver process read these live
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;

    // Exact speed in 0.1 km/h for a nonzero interval, before saturation
    function automatic logic [63:0] speed_for(input logic [wps_pkg::TS_W-1:0] interval);
        logic [63:0] num;
        logic [63:0] den;
        num = 64'(cfg_circ) * 64'(cfg_cps) * 64'd36;
        den = 64'(interval) * 64'd1000;
        return num / den;
    endfunction

    // Advance the model by one item and return the reading it produces
    function automatic wps_pkg::wps_out_t meter_step(input wps_pkg::wps_in_t it);
        logic [wps_pkg::TS_W-1:0] gap;
        logic [63:0]              spd;
        wps_pkg::wps_out_t        r;
        gap = it.timestamp - pulse_time;        // wraps mod 2^32
        r.display_changed = 1'b0;
        if (it.action == wps_pkg::ACT_PULSE) begin
            if (it.timestamp == pulse_time) begin
                r.status = wps_pkg::ST_DUPLICATE;
            end else if (pulse_time == '0) begin
                pulse_time = it.timestamp;
                r.status   = wps_pkg::ST_ARMED;
            end else begin
                spd = speed_for(gap);
                if (spd < 64'(cfg_limit)) begin
                    held_speed = spd[wps_pkg::SPEED_W-1:0];
                    if (odometer_mm > ({wps_pkg::DIST_W{1'b1}}
                                       - wps_pkg::DIST_W'(cfg_circ)))
                        odometer_mm = {wps_pkg::DIST_W{1'b1}};
                    else
                        odometer_mm = odometer_mm + wps_pkg::DIST_W'(cfg_circ);
                    pulse_time        = it.timestamp;
                    r.status          = wps_pkg::ST_ACCEPTED;
                    r.display_changed = 1'b1;
                end else begin
                    r.status = wps_pkg::ST_REJECTED;
                end
            end
        end else begin
            r.status = wps_pkg::ST_TICK_SAME;
            // zero interval counts as infinite speed: never lowers
            if (gap != '0) begin
                spd = speed_for(gap);
                if (spd > 64'hFFFF)
                    spd = 64'hFFFF;
                if (spd < 64'(held_speed)) begin
                    held_speed        = spd[wps_pkg::SPEED_W-1:0];
                    r.status          = wps_pkg::ST_TICK_LOW;
                    r.display_changed = 1'b1;
                end
            end
        end
        r.speed_tenths_kmh = held_speed;
        r.distance_mm      = odometer_mm;
        return r;
    endfunction

    // Random item, biased toward intervals near the limit so that pulses
    // land on both sides of it and ticks actually pull the speed down.
    function automatic wps_pkg::wps_in_t pick_item();
        logic [63:0]      num;
        logic [63:0]      thr;
        logic [63:0]      span;
        logic [63:0]      gap;
        int unsigned      sel;
        wps_pkg::wps_in_t it;
        num  = 64'(cfg_circ) * 64'(cfg_cps) * 64'd36;
        thr  = (cfg_limit == '0) ? 64'd1 : num / (64'(cfg_limit) * 64'd1000);
        span = thr / 4 + 3;
        sel  = $urandom_range(0, 99);
        it.action = wps_pkg::ACT_PULSE;
        gap       = '0;
        if (sel < 45) begin
            gap = 64'($urandom_range(0, 32'(span)));
            gap = $urandom_range(0, 1) ? thr + 1 + gap : ((thr > gap) ? thr - gap : 64'd1);
        end else if (sel < 65) begin
            it.action = wps_pkg::ACT_TICK;
            gap = 64'($urandom_range(0, 32'(8 * thr + 16)));
        end else if (sel < 73) begin
            gap = 64'($urandom);
        end else if (sel < 78) begin
            gap = '0;                           // duplicate pulse
        end else if (sel < 82) begin
            it.action = wps_pkg::ACT_TICK;      // tick at zero interval
        end else if (sel < 93) begin
            // free timestamps: pulse or tick anywhere, sometimes at zero
            it.action    = (sel >= 89) ? wps_pkg::ACT_TICK : wps_pkg::ACT_PULSE;
            it.timestamp = (sel < 86) ? wps_pkg::TS_W'($urandom)
                         : ((sel < 89) ? '0 : wps_pkg::TS_W'($urandom));
            return it;
        end else begin
            gap = 64'($urandom_range(1, 16));   // far too fast, mostly
        end
        it.timestamp = pulse_time + gap[wps_pkg::TS_W-1:0];
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows with known set carry a hand-read expectation;
    // the rest are checked against the model. Reset defaults apply:
    // speed = 72000 / interval, limit 1000.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                        action;
        logic [wps_pkg::TS_W-1:0]    timestamp;
        logic                        known;
        logic [wps_pkg::SPEED_W-1:0] speed;
        logic [wps_pkg::DIST_W-1:0]  distance;
        wps_pkg::wps_status_t        status;
        logic                        changed;
    } probe_t;

    localparam int NPROBE = 21;
    localparam probe_t PROBES [NPROBE] = '{
        // unarmed, zero gap
        '{wps_pkg::ACT_TICK,  32'd0,         1'b1, 16'd0, 32'd0,     wps_pkg::ST_TICK_SAME, 1'b0},
        // zero while unarmed
        '{wps_pkg::ACT_PULSE, 32'd0,         1'b1, 16'd0, 32'd0,     wps_pkg::ST_DUPLICATE, 1'b0},
        // unarmed tick
        '{wps_pkg::ACT_TICK,  32'd5,         1'b1, 16'd0, 32'd0,     wps_pkg::ST_TICK_SAME, 1'b0},
        '{wps_pkg::ACT_PULSE, 32'd1000,      1'b1, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_PULSE, 32'd1000,      1'b1, 16'd0, 32'd0,     wps_pkg::ST_DUPLICATE, 1'b0},
        '{wps_pkg::ACT_PULSE, 32'd1010,      1'b1, 16'd0, 32'd0,     wps_pkg::ST_REJECTED,  1'b0},
        // exactly at limit
        '{wps_pkg::ACT_PULSE, 32'd1072,      1'b1, 16'd0, 32'd0,     wps_pkg::ST_REJECTED,  1'b0},
        // just under
        '{wps_pkg::ACT_PULSE, 32'd1073,      1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_TICK,  32'd1073,      1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_TICK,  32'd2073,      1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        // decays to zero
        '{wps_pkg::ACT_TICK,  32'd101073,    1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_TICK,  32'd201073,    1'b1, 16'd0, 32'd2000,  wps_pkg::ST_TICK_SAME, 1'b0},
        '{wps_pkg::ACT_PULSE, 32'd2073,      1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_PULSE, 32'hFFFF_FFFF, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        // counter wrap
        '{wps_pkg::ACT_PULSE, 32'h0000_0050, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        // accepted at zero
        '{wps_pkg::ACT_PULSE, 32'd0,         1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_TICK,  32'hFFFF_FFFF, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        // re-arm
        '{wps_pkg::ACT_PULSE, 32'hFFFF_FFFF, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_PULSE, 32'hFFFF_FFFF, 1'b1, 16'd0, 32'd10000, wps_pkg::ST_DUPLICATE, 1'b0},
        '{wps_pkg::ACT_PULSE, 32'hAAAA_AAAA, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0},
        '{wps_pkg::ACT_TICK,  32'h5555_5555, 1'b0, 16'd0, 32'd0,     wps_pkg::ST_ARMED,     1'b0}
    };

    // ------------------------------------------------------------------
    // Input channel. Called right after a rising edge; returns at the edge
    // where the transfer happens. Valid is only dropped for a real gap, so
    // back-to-back items never see a low/high pair in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input wps_pkg::wps_in_t it, input logic known,
                             input wps_pkg::wps_out_t typed);
        wps_pkg::wps_out_t want;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        want = meter_step(it);
        pending_readings.push_back(known ? typed : want);
        items_sent++;
    endtask

    // Registers change only with nothing in flight
    task automatic load_settings(input logic [wps_pkg::CFG_W-1:0] circ_w,
                                 input logic [wps_pkg::CFG_W-1:0] cps_w,
                                 input logic [wps_pkg::CFG_W-1:0] limit_w);
        while (pending_readings.size() != 0)
            @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= wps_pkg::REG_CIRC;
        cfg_wdata <= circ_w;
        cfg_circ   = circ_w[wps_pkg::CIRC_W-1:0];   // upper bits are dropped
        @(posedge aclk);
        cfg_index <= wps_pkg::REG_CPS;
        cfg_wdata <= cps_w;
        cfg_cps    = cps_w;
        @(posedge aclk);
        cfg_index <= wps_pkg::REG_LIMIT;
        cfg_wdata <= limit_w;
        cfg_limit  = limit_w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure, then compare each transfer
    // with the oldest expected reading.
    // ------------------------------------------------------------------
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge aclk) begin : check_readings
        wps_pkg::wps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_data.status]++;
            if (pending_readings.size() == 0) begin
                $error("unexpected result transfer: speed %0d distance %0d status %0d",
                       m_data.speed_tenths_kmh, m_data.distance_mm, m_data.status);
                err_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_data.speed_tenths_kmh !== want.speed_tenths_kmh) begin
                    $error("speed_tenths_kmh: expected %0d, got %0d",
                           want.speed_tenths_kmh, m_data.speed_tenths_kmh);
                    err_count++;
                end
                if (m_data.distance_mm !== want.distance_mm) begin
                    $error("distance_mm: expected %0d, got %0d",
                           want.distance_mm, m_data.distance_mm);
                    err_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_count++;
                end
                if (m_data.display_changed !== want.display_changed) begin
                    $error("display_changed: expected %0d, got %0d",
                           want.display_changed, m_data.display_changed);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    localparam int NPHASE = 6;
    localparam int PHASE_ITEMS [NPHASE] = '{300, 250, 100, 300, 250, 250};

    initial begin : run_sequence
        wps_pkg::wps_in_t          it;
        wps_pkg::wps_out_t         typed;
        logic [wps_pkg::CFG_W-1:0] c_w;
        logic [wps_pkg::CFG_W-1:0] p_w;
        logic [wps_pkg::CFG_W-1:0] l_w;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // sender sparse, receiver choked for the first third
        snd_idle_pct = 27;
        rcv_idle_pct = 61;

        // directed part at reset register values
        for (int i = 0; i < NPROBE; i++) begin
            it.action                = PROBES[i].action;
            it.timestamp             = PROBES[i].timestamp;
            typed.speed_tenths_kmh   = PROBES[i].speed;
            typed.distance_mm        = PROBES[i].distance;
            typed.status             = PROBES[i].status;
            typed.display_changed    = PROBES[i].changed;
            send_item(it, PROBES[i].known, typed);
        end
        s_valid <= 1'b0;

        for (int p = 0; p < NPHASE; p++) begin
            case (p)
                0: begin                        // maxima; circumference word masked
                    c_w = 16'hFFFF;
                    p_w = 16'hFFFF;
                    l_w = 16'hFFFF;
                end
                1: begin                        // minima
                    c_w = 16'd1;
                    p_w = 16'd1;
                    l_w = 16'd1;
                end
                2: begin                        // all zero: speed 0, every timed pulse rejected
                    c_w = 16'd0;
                    p_w = 16'd0;
                    l_w = 16'd0;
                end
                3: begin                        // bicycle-like values
                    c_w = wps_pkg::CFG_W'($urandom_range(500, 2500));
                    p_w = wps_pkg::CFG_W'($urandom_range(1000, 65535));
                    l_w = wps_pkg::CFG_W'($urandom_range(100, 2000));
                end
                default: begin                  // anything legal, junk in upper bits
                    c_w = {4'($urandom), 12'($urandom_range(1, 4095))};
                    p_w = wps_pkg::CFG_W'($urandom_range(1, 65535));
                    l_w = wps_pkg::CFG_W'($urandom_range(1, 65535));
                end
            endcase
            load_settings(c_w, p_w, l_w);

            // swap the idle pattern in the middle third, none at the end
            if (p == 2) begin
                snd_idle_pct = 61;
                rcv_idle_pct = 27;
            end else if (p == 4) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                send_item(pick_item(), 1'b0, typed);
            s_valid <= 1'b0;
        end

        // drain, then give the block a little longer to misbehave
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (pending_readings.size() != 0) begin
            $error("%0d expected results never arrived", pending_readings.size());
            err_count++;
        end

        $display("%0d transfers under %0d register settings, with gaps on both channels",
                 items_sent, settings_used);
        $display("outcomes: armed %0d, accepted %0d, rejected %0d,",
                 status_seen[wps_pkg::ST_ARMED], status_seen[wps_pkg::ST_ACCEPTED],
                 status_seen[wps_pkg::ST_REJECTED]);
        $display("          tick kept %0d, tick lowered %0d, duplicate %0d",
                 status_seen[wps_pkg::ST_TICK_SAME], status_seen[wps_pkg::ST_TICK_LOW],
                 status_seen[wps_pkg::ST_DUPLICATE]);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: roughly ten times the slowest expected run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
